// ===== hdl/nksf_pkg.sv =====
// ----------------------------------------------------------------------------
// nksf_pkg
// Shared types and constants of the knot span finder: walk token, broadcast
// controls, sequencer states and command codes.
// ----------------------------------------------------------------------------
package nksf_pkg;

  // Defaults for the top level parameters
  localparam int KNOT_DEPTH_DEF = 128;
  localparam int KNOT_WIDTH_DEF = 32;
  localparam int MAX_ORDER_DEF  = 8;

  // Index width covers every store index and span length up to a depth of 4096
  localparam int IDX_W = 13;
  // Query parameter width
  localparam int T_W   = 32;

  // Register reset values
  localparam logic [3:0] ORDER_RST = 4'd4;
  localparam logic [6:0] COUNT_RST = 7'd4;

  // Input actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ORDER = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef logic [IDX_W-1:0] nksf_idx_t;

  // Which walk the token is on
  typedef enum logic {
    PASS_HINT,   // find the hint span start past runs of equal knots
    PASS_SPAN    // find the last knot not above t
  } nksf_pass_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_A,
    ST_PASS_A,
    ST_START_B,
    ST_PASS_B,
    ST_FINISH
  } nksf_state_t;

  // Held by the sequencer for the length of one walk
  typedef struct packed {
    nksf_pass_t pass;
    nksf_idx_t  lo;     // first store index of the walk window
    nksf_idx_t  hi;     // last store index of the window
  } nksf_bcast_t;

  // Running result handed from cell to cell
  typedef struct packed {
    logic      vld;
    nksf_idx_t hit;      // hint walk: run start; span walk: last knot <= t
    nksf_idx_t stop;     // where a from-below backoff from hit lands
    nksf_idx_t last_ne;  // last index whose knot differs from t
    logic      below;    // first window knot is above t
    logic      lt;       // t below the knot at hit
    logic      eq;       // t equal to the knot at hit
  } nksf_tok_t;

endpackage

// ===== hdl/nksf_cell.sv =====
// ----------------------------------------------------------------------------
// nksf_cell
// One knot slot of the chain: holds one knot, compares it with t when the
// walk token passes and hands the updated token to the next slot.
// ----------------------------------------------------------------------------
module nksf_cell import nksf_pkg::*; #(
  parameter int KNOT_WIDTH = KNOT_WIDTH_DEF,
  parameter int CELL_IDX   = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  nksf_idx_t                    wr_slot,
  input  logic signed [KNOT_WIDTH-1:0] wr_knot,
  input  logic signed [KNOT_WIDTH-1:0] prev_knot,
  input  logic signed [T_W-1:0]        param_t,
  input  nksf_bcast_t                  bcast,
  input  nksf_tok_t                    tok_in,
  output nksf_tok_t                    tok_out,
  output logic signed [KNOT_WIDTH-1:0] knot_out
);

  localparam int        CMPW   = (KNOT_WIDTH > T_W) ? KNOT_WIDTH : T_W;
  localparam nksf_idx_t MY_IDX = IDX_W'(CELL_IDX);

  logic signed [KNOT_WIDTH-1:0] knot_r;
  logic signed [CMPW-1:0]       knot_x;
  logic signed [CMPW-1:0]       t_x;
  logic                         in_win;
  logic                         t_lt;
  logic                         t_eq;
  logic                         tok_vld_r;
  nksf_tok_t                    tok_dat_r;
  nksf_tok_t                    tok_nxt;

  // Load the knot on a write beat aimed at this slot
  always_ff @(posedge clk) begin
    if (wr_en && (wr_slot == MY_IDX)) begin
      knot_r <= wr_knot;
    end
  end

  assign knot_out = knot_r;
  assign knot_x   = CMPW'(knot_r);
  assign t_x      = CMPW'(param_t);
  assign t_lt     = (t_x < knot_x);
  assign t_eq     = (t_x == knot_x);
  assign in_win   = (MY_IDX >= bcast.lo) && (MY_IDX <= bcast.hi);

  // Update the token when it sits on a slot inside the window
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && in_win) begin
      case (bcast.pass)
        PASS_HINT: begin
          // a new run of knots starts here
          if (knot_r != prev_knot) begin
            tok_nxt.hit = MY_IDX;
            tok_nxt.lt  = t_lt;
            tok_nxt.eq  = t_eq;
          end
        end
        PASS_SPAN: begin
          if (MY_IDX == bcast.lo) begin
            tok_nxt.below = t_lt;
          end else begin
            if (!t_lt) begin
              tok_nxt.hit  = MY_IDX;
              tok_nxt.stop = t_eq ? tok_in.last_ne : MY_IDX;
            end
            if (!t_eq) begin
              tok_nxt.last_ne = MY_IDX;
            end
          end
        end
        default: begin
          tok_nxt = tok_in;
        end
      endcase
    end
  end

  // Advance the token one slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_dat_r <= tok_nxt;
  end

  always_comb begin
    tok_out     = tok_dat_r;
    tok_out.vld = tok_vld_r;
  end

endmodule

// ===== hdl/nksf_ctrl.sv =====
// ----------------------------------------------------------------------------
// nksf_ctrl
// Query sequencer: checks the configuration, launches the hint walk and the
// span walk down the cell chain, folds their tokens into the span index and
// holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module nksf_ctrl import nksf_pkg::*; #(
  parameter int KNOT_DEPTH = KNOT_DEPTH_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic signed [T_W-1:0] in_param_t,
  input  logic signed [1:0]     in_side,
  input  logic [6:0]            in_hint,
  input  logic [3:0]            curve_order,
  input  logic [6:0]            control_count,
  output nksf_bcast_t           bcast,
  output nksf_tok_t             tok_head,
  input  nksf_tok_t             tok_tail,
  output logic signed [T_W-1:0] param_t,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [6:0]            out_span,
  output logic                  out_config_error
);

  localparam nksf_idx_t DEPTH_LIM = IDX_W'(KNOT_DEPTH + 2);
  localparam nksf_idx_t ORDER_LIM = IDX_W'(MAX_ORDER);
  localparam nksf_idx_t ONE       = IDX_W'(1);
  localparam nksf_idx_t TWO       = IDX_W'(2);

  nksf_state_t           state_r, state_nxt;
  logic signed [T_W-1:0] t_r, t_nxt;
  logic                  neg_r, neg_nxt;
  logic                  hint_ok_r, hint_ok_nxt;
  nksf_idx_t             b0_r, b0_nxt;
  nksf_idx_t             len0_r, len0_nxt;
  nksf_idx_t             base_r, base_nxt;
  nksf_idx_t             len_r, len_nxt;
  nksf_idx_t             h_r, h_nxt;
  nksf_pass_t            pass_r, pass_nxt;
  nksf_idx_t             lo_r, lo_nxt;
  nksf_idx_t             hi_r, hi_nxt;
  logic [6:0]            span_r, span_nxt;
  logic                  err_r, err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [6:0]            out_span_r, out_span_nxt;
  logic                  out_err_r, out_err_nxt;

  nksf_idx_t ord;
  nksf_idx_t cnt;
  nksf_idx_t hint;
  nksf_idx_t len0_q;
  logic      cfg_bad;
  logic      hint_ok_q;
  nksf_idx_t hp;
  nksf_idx_t hf;
  nksf_idx_t jrel;
  nksf_idx_t base_v;
  nksf_idx_t len_v;
  nksf_idx_t h_v;
  nksf_idx_t rel_v;
  logic      out_free;

  assign ord    = IDX_W'(curve_order);
  assign cnt    = IDX_W'(control_count);
  assign hint   = IDX_W'(in_hint);
  assign len0_q = cnt - ord + TWO;

  // Order out of range, too few points or more knots than the store holds
  assign cfg_bad = (ord < TWO) || (ord > ORDER_LIM) || (cnt < ord) ||
                   ((ord + cnt) > DEPTH_LIM);
  assign hint_ok_q = (hint != '0) && (hint < (len0_q - ONE));

  // Hint walk results: run start relative to the domain, backed off by one
  // when t sits on that knot and the limit is from below
  assign hp   = tok_tail.hit - b0_r;
  assign hf   = hp - IDX_W'(neg_r && tok_tail.eq);
  assign jrel = tok_tail.hit - base_r;

  assign out_free = !out_valid_r || !out_stall;

  // Window of the span walk
  always_comb begin
    base_v = b0_r;
    len_v  = len0_r;
    h_v    = '0;
    if (hint_ok_r && (hp != '0)) begin
      if (tok_tail.lt) begin
        len_v = hp + ONE;
      end else begin
        h_v    = hf;
        base_v = b0_r + hf;
        len_v  = len0_r - hf;
      end
    end
  end

  // Clamp into the domain and back up over knots equal to t
  always_comb begin
    if (tok_tail.below) begin
      rel_v = '0;
    end else if (jrel >= (len_r - ONE)) begin
      rel_v = len_r - TWO;
    end else if (neg_r) begin
      rel_v = tok_tail.stop - base_r;
    end else begin
      rel_v = jrel;
    end
  end

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    neg_nxt       = neg_r;
    hint_ok_nxt   = hint_ok_r;
    b0_nxt        = b0_r;
    len0_nxt      = len0_r;
    base_nxt      = base_r;
    len_nxt       = len_r;
    h_nxt         = h_r;
    pass_nxt      = pass_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    span_nxt      = span_r;
    err_nxt       = err_r;
    out_span_nxt  = out_span_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_action == ACT_QUERY)) begin
          t_nxt   = in_param_t;
          neg_nxt = in_side[1];
          if (cfg_bad) begin
            span_nxt  = '0;
            err_nxt   = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            err_nxt     = 1'b0;
            b0_nxt      = ord - TWO;
            len0_nxt    = len0_q;
            hint_ok_nxt = hint_ok_q;
            pass_nxt    = PASS_HINT;
            lo_nxt      = ord - ONE;
            hi_nxt      = hint_ok_q ? (ord - TWO + hint) : '0;
            state_nxt   = ST_START_A;
          end
        end
      end
      ST_START_A: begin
        state_nxt = ST_PASS_A;
      end
      ST_PASS_A: begin
        if (tok_tail.vld) begin
          base_nxt  = base_v;
          len_nxt   = len_v;
          h_nxt     = h_v;
          pass_nxt  = PASS_SPAN;
          lo_nxt    = base_v;
          hi_nxt    = base_v + len_v - ONE;
          state_nxt = ST_START_B;
        end
      end
      ST_START_B: begin
        state_nxt = ST_PASS_B;
      end
      ST_PASS_B: begin
        if (tok_tail.vld) begin
          span_nxt  = 7'(rel_v + h_r);
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_span_nxt  = span_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Launch a token at the head of the chain
  always_comb begin
    tok_head.vld     = (state_r == ST_START_A) || (state_r == ST_START_B);
    tok_head.hit     = (state_r == ST_START_A) ? b0_r : base_r;
    tok_head.stop    = base_r;
    tok_head.last_ne = base_r;
    tok_head.below   = 1'b0;
    tok_head.lt      = 1'b0;
    tok_head.eq      = 1'b0;
  end

  assign bcast.pass = pass_r;
  assign bcast.lo   = lo_r;
  assign bcast.hi   = hi_r;
  assign param_t    = t_r;

  assign out_valid        = out_valid_r;
  assign out_span         = out_span_r;
  assign out_config_error = out_err_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Query context and result payload
  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    neg_r      <= neg_nxt;
    hint_ok_r  <= hint_ok_nxt;
    b0_r       <= b0_nxt;
    len0_r     <= len0_nxt;
    base_r     <= base_nxt;
    len_r      <= len_nxt;
    h_r        <= h_nxt;
    pass_r     <= pass_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    span_r     <= span_nxt;
    err_r      <= err_nxt;
    out_span_r <= out_span_nxt;
    out_err_r  <= out_err_nxt;
  end

endmodule

// ===== hdl/nurbs_knot_span_finder_top.sv =====
// ----------------------------------------------------------------------------
// nurbs_knot_span_finder_top
// A query result goes valid after a hint walk and a span walk down the chain
// of KNOT_DEPTH cells, one cell per cycle; invalid settings skip both walks.
// One query in work: no new query is taken before the last leaves the
// sequencer. Writes are taken while a result waits in the output register; a
// stalled result holds the next query's result in the sequencer, and no input
// is taken meanwhile. Reset clears the walk and the result beat and sets
// order and count to 4; knots stay as written.
// ----------------------------------------------------------------------------
module nurbs_knot_span_finder_top import nksf_pkg::*; #(
  parameter int KNOT_DEPTH = KNOT_DEPTH_DEF,
  parameter int KNOT_WIDTH = KNOT_WIDTH_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [6:0]            cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [6:0]            in_knot_slot,
  input  logic signed [T_W-1:0] in_knot_value,
  input  logic signed [T_W-1:0] in_param_t,
  input  logic signed [1:0]     in_side,
  input  logic [6:0]            in_hint,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [6:0]            out_span,
  output logic                  out_config_error
);

  logic [3:0]                   curve_order_r;
  logic [6:0]                   control_count_r;
  logic                         wr_en;
  nksf_idx_t                    wr_slot;
  logic signed [KNOT_WIDTH-1:0] wr_knot;
  logic signed [T_W-1:0]        param_t;
  nksf_bcast_t                  bcast;
  nksf_tok_t                    tok_w [KNOT_DEPTH+1];
  logic signed [KNOT_WIDTH-1:0] knot_w [KNOT_DEPTH];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_order_r   <= ORDER_RST;
      control_count_r <= COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORDER: curve_order_r   <= cfg_wdata[3:0];
        CFG_COUNT: control_count_r <= cfg_wdata;
        default: begin
          curve_order_r <= curve_order_r;
        end
      endcase
    end
  end

  // Knot write beat, broadcast to all cells
  assign wr_en   = in_valid && !in_stall && (in_action == ACT_WRITE);
  assign wr_slot = IDX_W'(in_knot_slot);
  assign wr_knot = KNOT_WIDTH'(in_knot_value);

  nksf_ctrl #(
    .KNOT_DEPTH (KNOT_DEPTH),
    .MAX_ORDER  (MAX_ORDER)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_param_t       (in_param_t),
    .in_side          (in_side),
    .in_hint          (in_hint),
    .curve_order      (curve_order_r),
    .control_count    (control_count_r),
    .bcast            (bcast),
    .tok_head         (tok_w[0]),
    .tok_tail         (tok_w[KNOT_DEPTH]),
    .param_t          (param_t),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_span         (out_span),
    .out_config_error (out_config_error)
  );

  // Chain of knot cells
  for (genvar g = 0; g < KNOT_DEPTH; g++) begin : g_cell
    logic signed [KNOT_WIDTH-1:0] prev_knot;

    if (g == 0) begin : g_first
      assign prev_knot = knot_w[0];
    end else begin : g_rest
      assign prev_knot = knot_w[g-1];
    end

    nksf_cell #(
      .KNOT_WIDTH (KNOT_WIDTH),
      .CELL_IDX   (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_en),
      .wr_slot   (wr_slot),
      .wr_knot   (wr_knot),
      .prev_knot (prev_knot),
      .param_t   (param_t),
      .bcast     (bcast),
      .tok_in    (tok_w[g]),
      .tok_out   (tok_w[g+1]),
      .knot_out  (knot_w[g])
    );
  end

endmodule
